// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the governor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: sv/dtg_pkg.sv
// Package with the types and constants of the threshold frequency governor.
`default_nettype none

package dtg_pkg;

    localparam int FREQ_W     = 24;
    localparam int TIME_W     = 48;
    localparam int CNT_W      = 32;
    localparam int UTIL_W     = 7;
    localparam int HYST_W     = 5;
    localparam int QUOT_W     = 7;
    localparam int DIVD_W     = CNT_W + QUOT_W;
    localparam int RATE_W     = 31;
    localparam int WINDOW_W   = RATE_W + 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int BIT_W      = $clog2(QUOT_W);

    localparam logic [UTIL_W-1:0] PCT_FULL = UTIL_W'(100);

    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UTIL_HIGH   = 3'd0,
        REG_UTIL_MID    = 3'd1,
        REG_UTIL_LOW    = 3'd2,
        REG_UTIL_HYST   = 3'd3,
        REG_FREQ_HYST   = 3'd4,
        REG_RATE_LIMIT  = 3'd5,
        REG_PASSIVE     = 3'd6,
        REG_BOOST       = 3'd7
    } cfg_reg_t;

    localparam logic [UTIL_W-1:0]   RST_UTIL_HIGH = UTIL_W'(70);
    localparam logic [UTIL_W-1:0]   RST_UTIL_MID  = UTIL_W'(50);
    localparam logic [UTIL_W-1:0]   RST_UTIL_LOW  = UTIL_W'(30);
    localparam logic [HYST_W-1:0]   RST_UTIL_HYST = HYST_W'(5);
    localparam logic [FREQ_W-1:0]   RST_FREQ_HYST = FREQ_W'(100000);
    localparam logic [WINDOW_W-1:0] RST_WINDOW    = WINDOW_W'(10000000);

    typedef struct packed {
        logic [UTIL_W-1:0]   pct_max;
        logic [UTIL_W-1:0]   pct_boost;
        logic [UTIL_W-1:0]   pct_passive;
        logic [HYST_W-1:0]   util_hyst;
        logic [FREQ_W-1:0]   freq_hyst;
        logic [WINDOW_W-1:0] window_ns;
        logic [FREQ_W-1:0]   passive;
        logic [FREQ_W-1:0]   boost;
    } cfg_t;

    typedef struct packed {
        logic                is_sample;
        logic                util_zero;
        logic [TIME_W-1:0]   now;
        logic [DIVD_W-1:0]   dividend;
        logic [CNT_W-1:0]    total;
        logic [FREQ_W-1:0]   lo;
        logic [FREQ_W-1:0]   hi;
        logic [FREQ_W-1:0]   cur;
    } item_t;

    typedef struct packed {
        logic                freq_changed;
        logic [FREQ_W-1:0]   target;
        logic [UTIL_W-1:0]   utilization;
    } result_t;

endpackage

`default_nettype wire

// File: sv/dtg_front.sv
// Front end: accepts items, classifies them and scales idle time for the divider.
`default_nettype none

module dtg_front (
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic [dtg_pkg::TIME_W-1:0]    s_now_ns,
    input  wire logic [dtg_pkg::CNT_W-1:0]     s_idle_time,
    input  wire logic [dtg_pkg::CNT_W-1:0]     s_total_time,
    input  wire logic [dtg_pkg::FREQ_W-1:0]    s_min_freq_khz,
    input  wire logic [dtg_pkg::FREQ_W-1:0]    s_max_freq_khz,
    input  wire logic [dtg_pkg::FREQ_W-1:0]    s_cur_freq_khz,
    input  wire logic                          q_full,
    output logic                               q_push,
    output dtg_pkg::item_t                     q_item
);

    logic [dtg_pkg::DIVD_W-1:0] idle_ext;

    assign idle_ext = dtg_pkg::DIVD_W'(s_idle_time);
    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;

    always_comb begin
        q_item.is_sample = (s_req_type == dtg_pkg::REQ_SAMPLE);
        q_item.util_zero = (s_total_time == '0) || (s_idle_time > s_total_time);
        q_item.now       = s_now_ns;
        // Idle time times one hundred, as 64 + 32 + 4.
        q_item.dividend  = (idle_ext << 6) + (idle_ext << 5) + (idle_ext << 2);
        q_item.total     = s_total_time;
        q_item.lo        = s_min_freq_khz;
        q_item.hi        = s_max_freq_khz;
        q_item.cur       = s_cur_freq_khz;
    end

endmodule

`default_nettype wire

// File: sv/dtg_queue.sv
// Short queue of classified items between the front end and the back end.
`default_nettype none

module dtg_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire dtg_pkg::item_t  push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output dtg_pkg::item_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dtg_pkg::item_t   entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        res = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
        return res;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/dtg_back.sv
// Back end: rate limit check, serial utilization divider, level choice, hysteresis, clamp and result register.
`default_nettype none

module dtg_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dtg_pkg::cfg_t         cfg,
    input  wire logic                  q_valid,
    input  wire dtg_pkg::item_t        q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output dtg_pkg::result_t           m_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_PICK,
        ST_HOLD,
        ST_CLAMP,
        ST_OUT
    } state_t;

    state_t                         state_reg;
    dtg_pkg::item_t                 item_reg;
    logic [dtg_pkg::DIVD_W-1:0]     rem_reg;
    logic [dtg_pkg::QUOT_W-1:0]     quo_reg;
    logic [dtg_pkg::BIT_W-1:0]      bit_reg;
    logic [dtg_pkg::UTIL_W-1:0]     util_reg;
    logic [dtg_pkg::FREQ_W-1:0]     cand_reg;
    logic [dtg_pkg::FREQ_W-1:0]     held_reg;
    logic [dtg_pkg::FREQ_W-1:0]     prev_freq_reg;
    logic [dtg_pkg::TIME_W-1:0]     last_time_reg;
    dtg_pkg::result_t               res_reg;
    logic                           m_valid_reg;
    dtg_pkg::result_t               m_result_reg;

    logic [dtg_pkg::TIME_W-1:0]     elapsed;
    logic                           past_window;
    logic [dtg_pkg::DIVD_W-1:0]     divisor_sh;
    logic                           div_fits;
    logic [dtg_pkg::DIVD_W-1:0]     rem_next;
    logic [dtg_pkg::QUOT_W-1:0]     quo_next;
    logic [dtg_pkg::UTIL_W-1:0]     util_next;
    logic [dtg_pkg::HYST_W-1:0]     up_hi;
    logic [dtg_pkg::HYST_W-1:0]     up_bo;
    logic [dtg_pkg::HYST_W-1:0]     up_pa;
    logic [dtg_pkg::UTIL_W:0]       thr_hi;
    logic [dtg_pkg::UTIL_W:0]       thr_bo;
    logic [dtg_pkg::UTIL_W:0]       thr_pa;
    logic [dtg_pkg::UTIL_W:0]       util_ext;
    logic [dtg_pkg::FREQ_W-1:0]     cand_next;
    logic [dtg_pkg::FREQ_W-1:0]     diff;
    logic [dtg_pkg::FREQ_W-1:0]     held_next;
    logic [dtg_pkg::FREQ_W-1:0]     floor_f;
    logic [dtg_pkg::FREQ_W-1:0]     final_f;
    logic                           out_free;
    logic                           load_out;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_OUT) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    always_comb begin
        // A sample is evaluated only when it lies at or beyond the end of the window.
        elapsed     = item_reg.now - last_time_reg;
        past_window = (item_reg.now >= last_time_reg)
                      && (elapsed >= dtg_pkg::TIME_W'(cfg.window_ns));

        divisor_sh = dtg_pkg::DIVD_W'(item_reg.total) << bit_reg;
        div_fits   = (rem_reg >= divisor_sh);
        rem_next   = div_fits ? rem_reg - divisor_sh : rem_reg;
        quo_next   = div_fits ? quo_reg | (dtg_pkg::QUOT_W'(1) << bit_reg) : quo_reg;
        util_next  = dtg_pkg::PCT_FULL - quo_next;

        up_hi    = (prev_freq_reg < item_reg.hi) ? cfg.util_hyst : '0;
        up_bo    = (prev_freq_reg < cfg.boost) ? cfg.util_hyst : '0;
        up_pa    = (prev_freq_reg < cfg.passive) ? cfg.util_hyst : '0;
        thr_hi   = {1'b0, cfg.pct_max} + (dtg_pkg::UTIL_W + 1)'(up_hi);
        thr_bo   = {1'b0, cfg.pct_boost} + (dtg_pkg::UTIL_W + 1)'(up_bo);
        thr_pa   = {1'b0, cfg.pct_passive} + (dtg_pkg::UTIL_W + 1)'(up_pa);
        util_ext = {1'b0, util_reg};

        priority if (util_ext >= thr_hi) begin
            cand_next = item_reg.hi;
        end else if (util_ext >= thr_bo) begin
            cand_next = cfg.boost;
        end else if (util_ext >= thr_pa) begin
            cand_next = cfg.passive;
        end else begin
            cand_next = item_reg.lo;
        end

        diff      = (cand_reg >= prev_freq_reg) ? cand_reg - prev_freq_reg
                                                : prev_freq_reg - cand_reg;
        held_next = (diff < cfg.freq_hyst) ? prev_freq_reg : cand_reg;

        floor_f = (held_reg < item_reg.lo) ? item_reg.lo : held_reg;
        final_f = (floor_f > item_reg.hi) ? item_reg.hi : floor_f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            prev_freq_reg <= '0;
            last_time_reg <= '0;
        end else begin
            if (load_out) begin
                m_valid_reg  <= 1'b1;
                m_result_reg <= res_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (!item_reg.is_sample) begin
                        prev_freq_reg <= item_reg.cur;
                        last_time_reg <= item_reg.now;
                        res_reg       <= '{freq_changed: 1'b0, target: item_reg.cur,
                                           utilization: '0};
                        state_reg     <= ST_OUT;
                    end else if (!past_window) begin
                        res_reg   <= '{freq_changed: 1'b0, target: prev_freq_reg,
                                       utilization: '0};
                        state_reg <= ST_OUT;
                    end else if (item_reg.util_zero) begin
                        util_reg  <= '0;
                        state_reg <= ST_PICK;
                    end else begin
                        rem_reg   <= item_reg.dividend;
                        quo_reg   <= '0;
                        bit_reg   <= dtg_pkg::BIT_W'(dtg_pkg::QUOT_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    if (bit_reg == '0) begin
                        util_reg  <= util_next;
                        state_reg <= ST_PICK;
                    end else begin
                        bit_reg <= bit_reg - dtg_pkg::BIT_W'(1);
                    end
                end
                ST_PICK: begin
                    cand_reg  <= cand_next;
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    held_reg  <= held_next;
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    res_reg <= '{freq_changed: (final_f != prev_freq_reg), target: final_f,
                                 utilization: util_reg};
                    if (final_f != prev_freq_reg) begin
                        prev_freq_reg <= final_f;
                        last_time_reg <= item_reg.now;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/dvfs_threshold_governor.sv
// Top level of the threshold frequency governor with hysteresis.
// Usage: the input channel (s_valid / s_ready) takes one item per handshake. A
// start item (req_type 0) loads the current frequency and the time stamp; a
// sample item (req_type 1) carries idle and total time and the policy limits.
// Every item gives exactly one result on the output channel (m_valid /
// m_ready): the change flag, the target frequency and the utilization percent.
// A start item or a rate-limited sample passes the states IDLE, CHECK and OUT;
// a sample with zero total or idle above total passes IDLE, CHECK, PICK, HOLD,
// CLAMP and OUT; an evaluated sample also passes DIV, where the restoring
// divider steps one quotient bit per cycle. The back end works on one item at a
// time, so it takes a new item only after the result of the last one is loaded
// into the output register.
// Items are accepted into a QUEUE_DEPTH deep queue while the back end is busy
// or a result waits; s_ready drops only when that queue is full. When the
// receiver stalls, the result register holds its item and the back end waits
// with the next finished result. Reset is synchronous and active low: it
// empties the queue, drops m_valid, clears last frequency and change time, and
// loads the configuration registers with their defaults. Configuration writes
// (cfg_we, cfg_index, cfg_wdata) take effect at the next clock edge.
`default_nettype none

module dvfs_threshold_governor #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [dtg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dtg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_req_type,
    input  wire logic [dtg_pkg::TIME_W-1:0]       s_now_ns,
    input  wire logic [dtg_pkg::CNT_W-1:0]        s_idle_time,
    input  wire logic [dtg_pkg::CNT_W-1:0]        s_total_time,
    input  wire logic [dtg_pkg::FREQ_W-1:0]       s_min_freq_khz,
    input  wire logic [dtg_pkg::FREQ_W-1:0]       s_max_freq_khz,
    input  wire logic [dtg_pkg::FREQ_W-1:0]       s_cur_freq_khz,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_freq_changed,
    output logic [dtg_pkg::FREQ_W-1:0]            m_target_freq_khz,
    output logic [dtg_pkg::UTIL_W-1:0]            m_utilization
);

    dtg_pkg::cfg_t                   cfg_reg;
    logic [dtg_pkg::WINDOW_W-1:0]    rate_ext;
    logic [dtg_pkg::WINDOW_W-1:0]    window_next;
    logic                            q_full;
    logic                            q_push;
    dtg_pkg::item_t                  push_item;
    logic                            q_pop;
    logic                            q_valid;
    dtg_pkg::item_t                  q_head;
    dtg_pkg::result_t                result;

    // Microseconds to nanoseconds: times 1024 - 16 - 8.
    assign rate_ext    = dtg_pkg::WINDOW_W'(cfg_wdata[dtg_pkg::RATE_W-1:0]);
    assign window_next = (rate_ext << 10) - (rate_ext << 4) - (rate_ext << 3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pct_max     <= dtg_pkg::RST_UTIL_HIGH;
            cfg_reg.pct_boost   <= dtg_pkg::RST_UTIL_MID;
            cfg_reg.pct_passive <= dtg_pkg::RST_UTIL_LOW;
            cfg_reg.util_hyst   <= dtg_pkg::RST_UTIL_HYST;
            cfg_reg.freq_hyst   <= dtg_pkg::RST_FREQ_HYST;
            cfg_reg.window_ns   <= dtg_pkg::RST_WINDOW;
            cfg_reg.passive     <= '0;
            cfg_reg.boost       <= '0;
        end else if (cfg_we) begin
            unique case (dtg_pkg::cfg_reg_t'(cfg_index))
                dtg_pkg::REG_UTIL_HIGH: begin
                    cfg_reg.pct_max <= cfg_wdata[dtg_pkg::UTIL_W-1:0];
                end
                dtg_pkg::REG_UTIL_MID: begin
                    cfg_reg.pct_boost <= cfg_wdata[dtg_pkg::UTIL_W-1:0];
                end
                dtg_pkg::REG_UTIL_LOW: begin
                    cfg_reg.pct_passive <= cfg_wdata[dtg_pkg::UTIL_W-1:0];
                end
                dtg_pkg::REG_UTIL_HYST: begin
                    cfg_reg.util_hyst <= cfg_wdata[dtg_pkg::HYST_W-1:0];
                end
                dtg_pkg::REG_FREQ_HYST: begin
                    cfg_reg.freq_hyst <= cfg_wdata[dtg_pkg::FREQ_W-1:0];
                end
                dtg_pkg::REG_RATE_LIMIT: begin
                    cfg_reg.window_ns <= window_next;
                end
                dtg_pkg::REG_PASSIVE: begin
                    cfg_reg.passive <= cfg_wdata[dtg_pkg::FREQ_W-1:0];
                end
                dtg_pkg::REG_BOOST: begin
                    cfg_reg.boost <= cfg_wdata[dtg_pkg::FREQ_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    dtg_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_now_ns       (s_now_ns),
        .s_idle_time    (s_idle_time),
        .s_total_time   (s_total_time),
        .s_min_freq_khz (s_min_freq_khz),
        .s_max_freq_khz (s_max_freq_khz),
        .s_cur_freq_khz (s_cur_freq_khz),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    dtg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    dtg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_freq_changed    = result.freq_changed;
    assign m_target_freq_khz = result.target;
    assign m_utilization     = result.utilization;

endmodule

`default_nettype wire

// File: sv/dtg_checker.sv
// Port-level checker for the governor and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module dtg_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic                           m_freq_changed,
    input  wire logic [dtg_pkg::FREQ_W-1:0]     m_target_freq_khz,
    input  wire logic [dtg_pkg::UTIL_W-1:0]     m_utilization
);

    `ASSERT_CLK_ALWAYS(a_reset_drops_valid, aclk, !aresetn |=> !m_valid, "m_valid after reset")
    `ASSERT_CLK(a_util_range, aclk, aresetn, m_valid |-> m_utilization <= dtg_pkg::PCT_FULL, "utilization above 100")
    `ASSERT_CLK(a_valid_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `ASSERT_CLK(a_target_holds, aclk, aresetn, m_valid && !m_ready |=> $stable(m_target_freq_khz) && $stable(m_freq_changed), "result changed while stalled")

endmodule

bind dvfs_threshold_governor dtg_checker u_dtg_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_freq_changed    (m_freq_changed),
    .m_target_freq_khz (m_target_freq_khz),
    .m_utilization     (m_utilization)
);

`default_nettype wire
